@@ hdl/four_tap_rgb_blend_lut_pack_top_macros.svh @@
// Assertion macros for the four-tap blend and lookup-table pack block
`ifndef FOUR_TAP_RGB_BLEND_LUT_PACK_TOP_MACROS_SVH
`define FOUR_TAP_RGB_BLEND_LUT_PACK_TOP_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the cycle after the antecedent
`define FTBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define FTBL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define FTBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define FTBL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hdl/ftbl_pkg.sv @@
// Shared types and constants for the four-tap blend and lookup-table pack block
`timescale 1ns / 1ps

package ftbl_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned TapW    = 24;
	localparam int unsigned WeightW = 32;
	localparam int unsigned EntryW  = 16;
	localparam int unsigned NumTaps = 4;
	localparam int unsigned LutDepth = 256;
	localparam int unsigned ProdW   = 2 * ChanW;
	localparam int unsigned AccW    = ProdW + 2;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_LOAD  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		SEL_RED   = 2'd0,
		SEL_GREEN = 2'd1,
		SEL_BLUE  = 2'd2
	} table_sel_t;

	typedef struct packed {
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] red;
	} chan_t;

	typedef struct packed {
		logic                en;
		table_sel_t          sel;
		logic [ChanW-1:0]    idx;
		logic [EntryW-1:0]   val;
	} lut_wr_t;

	typedef struct packed {
		logic  en;
		chan_t addr;
	} lut_rd_t;

	typedef struct packed {
		logic [EntryW-1:0] blue;
		logic [EntryW-1:0] green;
		logic [EntryW-1:0] red;
	} entries_t;

endpackage

@@ hdl/four_tap_rgb_blend_lut_pack_top.sv @@
// A pixel passes the input, table read and output registers to m_axis. Throughput:
//   one transaction per cycle unless m_axis stalls; blend logic sits between the input
//   register and the table read port, the three-entry add between read register and output.
// Load transactions write at most one table entry at the input stage and give no result.
// Reset (arst_n, asynchronous, active low) clears the valid flags only; tables are
//   undefined until written.
`timescale 1ns / 1ps
`include "four_tap_rgb_blend_lut_pack_top_macros.svh"

module four_tap_rgb_blend_lut_pack_top import ftbl_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// [23:0] tap_zero, [47:24] tap_one, [71:48] tap_two, [95:72] tap_three,
	// [127:96] weight_quad, [135:128] table_index, [151:136] table_value
	input  logic [151:0]  s_axis_tdata,
	// [0] opcode, [1] point_sample, [3:2] table_select
	input  logic [3:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// [15:0] pixel_out
	output logic [15:0]   m_axis_tdata
);

	logic                valid_s1;
	opcode_t             op_s1;
	logic                point_s1;
	table_sel_t          sel_s1;
	logic [TapW-1:0]     tap0_s1, tap1_s1, tap2_s1, tap3_s1;
	logic [WeightW-1:0]  weight_s1;
	logic [ChanW-1:0]    idx_s1;
	logic [EntryW-1:0]   val_s1;

	logic                valid_s2;
	logic                out_valid_q;
	logic [EntryW-1:0]   out_data_q;

	logic                out_en, s2_en, s1_en;
	chan_t               chan;
	lut_wr_t             wr;
	lut_rd_t             rd;
	entries_t            ent_s2;

	// Each stage advances when the one after it is empty or moving
	assign out_en        = !out_valid_q || m_axis_tready;
	assign s2_en         = !valid_s2 || out_en;
	assign s1_en         = !valid_s1 || s2_en;
	assign s_axis_tready = s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && s_axis_tvalid) begin
			op_s1     <= opcode_t'(s_axis_tuser[0]);
			point_s1  <= s_axis_tuser[1];
			sel_s1    <= table_sel_t'(s_axis_tuser[3:2]);
			tap0_s1   <= s_axis_tdata[23:0];
			tap1_s1   <= s_axis_tdata[47:24];
			tap2_s1   <= s_axis_tdata[71:48];
			tap3_s1   <= s_axis_tdata[95:72];
			weight_s1 <= s_axis_tdata[127:96];
			idx_s1    <= s_axis_tdata[135:128];
			val_s1    <= s_axis_tdata[151:136];
		end
	end

	ftbl_blend u_blend (
		.point_sample (point_s1),
		.tap_zero     (tap0_s1),
		.tap_one      (tap1_s1),
		.tap_two      (tap2_s1),
		.tap_three    (tap3_s1),
		.weight_quad  (weight_s1),
		.chan         (chan)
	);

	// Loads retire at stage one; only pixels move on to the read stage
	always_comb begin
		wr.en   = valid_s1 && (op_s1 == OP_LOAD) && s2_en;
		wr.sel  = sel_s1;
		wr.idx  = idx_s1;
		wr.val  = val_s1;
		rd.en   = valid_s1 && (op_s1 == OP_PIXEL) && s2_en;
		rd.addr = chan;
	end

	ftbl_lut u_lut (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (ent_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_en) begin
			valid_s2 <= valid_s1 && (op_s1 == OP_PIXEL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			out_data_q <= ent_s2.red + ent_s2.green + ent_s2.blue;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`FTBL_ASSERT_NEXT(a_load_no_result, clk, arst_n, (valid_s1 && (op_s1 == OP_LOAD) && s2_en), !valid_s2, "load transaction reached the read stage")
	`FTBL_ASSERT_SAME(a_full_stall, clk, arst_n, (valid_s1 && valid_s2 && out_valid_q && !m_axis_tready), !s_axis_tready, "input taken while pipeline is full and stalled")
	`FTBL_ASSERT_NEXT(a_read_to_out, clk, arst_n, (valid_s2 && out_en), m_axis_tvalid, "read-stage pixel lost before output")
	`FTBL_ASSERT_SAME(a_no_write_read, clk, arst_n, wr.en, !rd.en, "table write and read issued together")

endmodule

@@ hdl/ftbl_blend.sv @@
// Four-tap weighted channel blend with point-sample bypass
`timescale 1ns / 1ps

module ftbl_blend import ftbl_pkg::*; (
	input  logic                 point_sample,
	input  logic [TapW-1:0]      tap_zero,
	input  logic [TapW-1:0]      tap_one,
	input  logic [TapW-1:0]      tap_two,
	input  logic [TapW-1:0]      tap_three,
	input  logic [WeightW-1:0]   weight_quad,
	output chan_t                chan
);

	logic [TapW-1:0]  taps [NumTaps];
	logic [ChanW-1:0] blended [3];

	assign taps[0] = tap_zero;
	assign taps[1] = tap_one;
	assign taps[2] = tap_two;
	assign taps[3] = tap_three;

	// Per channel: sum of four 8x8 products, keep bits 15..8 of the wrapped sum
	always_comb begin
		logic [AccW-1:0] acc;
		for (int c = 0; c < 3; c++) begin
			acc = '0;
			for (int k = 0; k < NumTaps; k++) begin
				acc = acc + AccW'(weight_quad[k*ChanW +: ChanW] * taps[k][c*ChanW +: ChanW]);
			end
			blended[c] = acc[ProdW-1:ChanW];
		end
	end

	always_comb begin
		if (point_sample) begin
			chan.red   = tap_zero[0*ChanW +: ChanW];
			chan.green = tap_zero[1*ChanW +: ChanW];
			chan.blue  = tap_zero[2*ChanW +: ChanW];
		end else begin
			chan.red   = blended[0];
			chan.green = blended[1];
			chan.blue  = blended[2];
		end
	end

endmodule

@@ hdl/ftbl_lut.sv @@
// Three 256 x 16 lookup tables, one write port and one registered read each
`timescale 1ns / 1ps

module ftbl_lut import ftbl_pkg::*; (
	input  logic     clk,
	input  lut_wr_t  wr,
	input  lut_rd_t  rd,
	output entries_t rdata
);

	logic [EntryW-1:0] red_mem   [LutDepth];
	logic [EntryW-1:0] green_mem [LutDepth];
	logic [EntryW-1:0] blue_mem  [LutDepth];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			case (wr.sel)
				SEL_RED:   red_mem[wr.idx]   <= wr.val;
				SEL_GREEN: green_mem[wr.idx] <= wr.val;
				SEL_BLUE:  blue_mem[wr.idx]  <= wr.val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata.red   <= red_mem[rd.addr.red];
			rdata.green <= green_mem[rd.addr.green];
			rdata.blue  <= blue_mem[rd.addr.blue];
		end
	end

endmodule

@@ dv/four_tap_rgb_blend_lut_pack_top_test.sv @@
// Self-checking testbench for the four-tap RGB blend and lookup-table pack block
`timescale 1ns / 1ps

module four_tap_rgb_blend_lut_pack_top_test;
	import ftbl_pkg::*;

	localparam logic [1:0]  SEL_NONE    = 2'd3;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 700;

	typedef struct packed {
		logic [15:0]      value;
		logic [7:0]       index;
		logic [1:0]       sel;
		logic [3:0][7:0]  weights;
		logic [3:0][23:0] taps;
		logic             point;
		opcode_t          op;
	} blend_req_t;

	logic         clk;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [151:0] s_axis_tdata  = '0;
	logic [3:0]   s_axis_tuser  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [15:0]  m_axis_tdata;

	logic [15:0]  lut [3][256];
	logic [15:0]  pixel_expq [$];
	int unsigned  fail_count = 0;
	bit           gaps_on    = 1'b1;
	logic         rx_taken   = 1'b0;
	int unsigned  rx_stall   = 0;

	four_tap_rgb_blend_lut_pack_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic log_fault(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	function automatic logic [15:0] predict_pixel(input blend_req_t r);
		logic [7:0]  chan [3];
		logic [15:0] acc;
		for (int c = 0; c < 3; c++) begin
			if (r.point) begin
				chan[c] = r.taps[0][8*c +: 8];
			end else begin
				// wrap to 16 bits before taking the high byte
				acc = '0;
				for (int k = 0; k < 4; k++) begin
					acc = acc + 16'(r.weights[k]) * 16'(r.taps[k][8*c +: 8]);
				end
				chan[c] = acc[15:8];
			end
		end
		return lut[SEL_RED][chan[0]] + lut[SEL_GREEN][chan[1]] + lut[SEL_BLUE][chan[2]];
	endfunction

	function automatic blend_req_t load_req(input logic [1:0] sel, input logic [7:0] index,
			input logic [15:0] value);
		blend_req_t r;
		r.op      = OP_LOAD;
		r.sel     = sel;
		r.index   = index;
		r.value   = value;
		r.point   = 1'($urandom);
		r.weights = $urandom;
		r.taps    = {$urandom, $urandom, $urandom};
		return r;
	endfunction

	function automatic blend_req_t pixel_req(input logic point, input logic [3:0][23:0] taps,
			input logic [3:0][7:0] weights);
		blend_req_t r;
		r.op      = OP_PIXEL;
		r.point   = point;
		r.taps    = taps;
		r.weights = weights;
		r.sel     = 2'($urandom);
		r.index   = 8'($urandom);
		r.value   = 16'($urandom);
		return r;
	endfunction

	// Entered and left at a falling edge with nothing scheduled in that step.
	task automatic send_item(input blend_req_t r);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.value, r.index, r.weights, r.taps};
		s_axis_tuser  <= {r.sel, r.point, r.op};
		do @(posedge clk); while (!s_axis_tready);
		if (r.op == OP_LOAD) begin
			if (r.sel != SEL_NONE) begin
				lut[r.sel][r.index] = r.value;
			end
		end else begin
			pixel_expq.push_back(predict_pixel(r));
		end
		@(negedge clk);
	endtask

	task automatic wait_for_pixels();
		s_axis_tvalid <= 1'b0;
		while (pixel_expq.size() != 0) @(negedge clk);
	endtask

	// Every entry is written here, so no later pixel can read an unwritten one.
	task automatic load_all_tables();
		logic [15:0] value;
		gaps_on = 1'b1;
		for (int s = 0; s < 3; s++) begin
			for (int i = 0; i < 256; i++) begin
				value = 16'($urandom);
				if (i == 0) value = 16'h0000;
				if (i == 255) value = 16'hFFFF;
				send_item(load_req(2'(s), 8'(i), value));
			end
		end
	endtask

	task automatic run_corner_cases();
		logic [3:0][7:0] one_hot;
		gaps_on = 1'b0;
		// point sample: unused taps and weights at all ones, then all taps ones and weights zero
		send_item(pixel_req(1'b1, {{3{24'hFFFFFF}}, 24'h000000}, 32'hFFFFFFFF));
		send_item(pixel_req(1'b1, {4{24'hFFFFFF}}, 32'h00000000));
		// blend: zero weights, full weights on full taps to wrap the sum, on zero taps, then one-hot
		send_item(pixel_req(1'b0, {4{24'hFFFFFF}}, 32'h00000000));
		send_item(pixel_req(1'b0, {4{24'hFFFFFF}}, 32'hFFFFFFFF));
		send_item(pixel_req(1'b0, {4{24'h000000}}, 32'hFFFFFFFF));
		for (int k = 0; k < 4; k++) begin
			one_hot    = '0;
			one_hot[k] = 8'hFF;
			send_item(pixel_req(1'b0, {$urandom, $urandom, $urandom}, one_hot));
		end
		// unused table select must leave every table untouched
		send_item(load_req(SEL_NONE, 8'hFF, 16'hFFFF));
		send_item(load_req(SEL_NONE, 8'h00, 16'h1234));
		send_item(pixel_req(1'b1, {24'($urandom), 24'($urandom), 24'($urandom), 24'hFF00FF},
			$urandom));
		// read straight after write, one per table, back to back
		send_item(load_req(SEL_RED, 8'h37, 16'hFFFF));
		send_item(pixel_req(1'b1, {24'($urandom), 24'($urandom), 24'($urandom), 24'hFFFF37},
			$urandom));
		send_item(load_req(SEL_GREEN, 8'hA5, 16'h8001));
		send_item(pixel_req(1'b1, {24'($urandom), 24'($urandom), 24'($urandom), 24'h00A537},
			$urandom));
		send_item(load_req(SEL_BLUE, 8'h5A, 16'h0000));
		send_item(pixel_req(1'b1, {24'($urandom), 24'($urandom), 24'($urandom), 24'h5AA537},
			$urandom));
		send_item(load_req(SEL_RED, 8'hFF, 16'hFFFF));
		send_item(load_req(SEL_GREEN, 8'hFF, 16'hFFFF));
		send_item(load_req(SEL_BLUE, 8'hFF, 16'hFFFF));
		send_item(pixel_req(1'b1, {24'($urandom), 24'($urandom), 24'($urandom), 24'hFFFFFF},
			$urandom));
		wait_for_pixels();
	endtask

	task automatic run_random_stream();
		int unsigned      pick;
		logic [1:0]       last_sel;
		logic [7:0]       last_index;
		logic [3:0][23:0] taps;
		logic [31:0]      weights;
		last_sel   = SEL_RED;
		last_index = 8'h00;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// two stretches with gaps, then one without
			if (i % 150 == 0) gaps_on = ((i / 150) % 3) != 2;
			if (i % 250 == 249) wait_for_pixels();
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				last_sel   = (pick < 2) ? SEL_NONE : 2'($urandom_range(0, 2));
				last_index = 8'($urandom);
				send_item(load_req(last_sel, last_index, 16'($urandom)));
			end else begin
				taps    = {$urandom, $urandom, $urandom};
				weights = $urandom;
				if (pick < 55 && last_sel != SEL_NONE) begin
					taps[0][8*last_sel +: 8] = last_index;
				end
				// on even picks, cap each weight at 63 so the four sum to at most 252
				if (pick % 2 == 0) weights = weights & 32'h3F3F3F3F;
				send_item(pixel_req(pick < 65, taps, weights));
			end
		end
		wait_for_pixels();
	endtask

	always @(negedge clk) begin
		if (rx_taken) begin
			rx_stall = gaps_on ? $urandom_range(0, 7) : 0;
		end
		if (rx_stall != 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_pixels
		logic [15:0] want;
		rx_taken <= m_axis_tvalid && m_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pixel_expq.size() == 0) begin
				log_fault($sformatf("unexpected pixel %h", m_axis_tdata));
			end else begin
				want = pixel_expq.pop_front();
				if (m_axis_tdata !== want) begin
					log_fault($sformatf("pixel_out mismatch: expected %h, got %h",
						want, m_axis_tdata));
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		load_all_tables();
		run_corner_cases();
		run_random_stream();
		s_axis_tvalid <= 1'b0;
		// let any stray transaction show up past the pipeline
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ four_tap_rgb_blend_lut_pack_top.f @@
+incdir+hdl
hdl/ftbl_pkg.sv
hdl/ftbl_blend.sv
hdl/ftbl_lut.sv
hdl/four_tap_rgb_blend_lut_pack_top.sv
dv/four_tap_rgb_blend_lut_pack_top_test.sv
